// File: rtl/core/i2cms_pkg.sv
// Shared types, codes and defaults of the I2C master register sequencer.
package i2cms_pkg;

  localparam int REG_MAX_DEF  = 4;
  localparam int TX_DEPTH_DEF = 256;

  // Largest read length in bytes.
  localparam int RX_MAX = 256;

  typedef enum logic [2:0] {
    FN_LOAD_REG,
    FN_LOAD_DATA,
    FN_REQUEST,
    FN_START_DONE,
    FN_TX_SEL,
    FN_BYTE_SENT,
    FN_RX_SEL,
    FN_BYTE_RCVD
  } func_t;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CMD   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    func_t      func;
    logic [1:0] kind;
    logic [6:0] write_addr;
    logic [6:0] read_addr;
    logic [2:0] reg_count;
    logic [8:0] data_count;
    logic [7:0] load_index;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       gen_start;
    logic       addr_valid;
    logic [6:0] addr_value;
    logic       addr_read;
    logic       send_valid;
    logic [7:0] send_value;
    logic       gen_stop;
    logic       ack_enable;
    logic       rx_valid;
    logic [7:0] rx_value;
    logic [7:0] rx_index;
  } out_item_t;

endpackage

// File: rtl/core/i2cms_if.sv
// Valid/ready channel interfaces for sequencer items and results.
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [1:0] kind;
  logic [6:0] write_addr;
  logic [6:0] read_addr;
  logic [2:0] reg_count;
  logic [8:0] data_count;
  logic [7:0] load_index;
  logic [7:0] data_byte;

  modport source (
    output valid, func, kind, write_addr, read_addr, reg_count, data_count,
           load_index, data_byte,
    input  ready
  );
  modport sink (
    input  valid, func, kind, write_addr, read_addr, reg_count, data_count,
           load_index, data_byte,
    output ready
  );
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       gen_start;
  logic       addr_valid;
  logic [6:0] addr_value;
  logic       addr_read;
  logic       send_valid;
  logic [7:0] send_value;
  logic       gen_stop;
  logic       ack_enable;
  logic       rx_valid;
  logic [7:0] rx_value;
  logic [7:0] rx_index;

  modport source (
    output valid, status, gen_start, addr_valid, addr_value, addr_read,
           send_valid, send_value, gen_stop, ack_enable, rx_valid, rx_value,
           rx_index,
    input  ready
  );
  modport sink (
    input  valid, status, gen_start, addr_valid, addr_value, addr_read,
           send_valid, send_value, gen_stop, ack_enable, rx_valid, rx_value,
           rx_index,
    output ready
  );
endinterface

// File: rtl/core/i2cms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/i2c_master_register_sequencer_unit.sv
// Top level of the I2C master register-transaction sequencer.
// The item sits in the input register, and its result loads into the
// result register once that register is free or being emptied.
// Throughput: one item per cycle; an item enters while the previous result
// waits, and the pipeline stalls only when the result register is held.
// Reset (rst, synchronous): phase to idle, counters and addresses to zero,
// valid flags cleared; the register and data byte stores are not cleared.
module i2c_master_register_sequencer_unit
  import i2cms_pkg::*;
#(
  parameter int REG_MAX  = REG_MAX_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  i2cms_in_if.sink   req,
  i2cms_out_if.source rsp
);

  // Widths of the store indexes and of the position/length counters.
  localparam int RW  = (REG_MAX > 1) ? $clog2(REG_MAX) : 1;
  localparam int RPW = $clog2(REG_MAX + 1);
  localparam int AW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int DPW = $clog2(((TX_DEPTH > RX_MAX) ? TX_DEPTH : RX_MAX) + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WRITE,
    PH_CMD,
    PH_TXREG,
    PH_RX
  } phase_t;

  // Input register.
  in_item_t iq;
  logic     iq_valid;

  // Transaction state.
  phase_t         phase, phase_next;
  logic [6:0]     slave_write_addr, slave_write_addr_next;
  logic [6:0]     slave_read_addr, slave_read_addr_next;
  logic [RPW-1:0] reg_pos, reg_pos_next;
  logic [RPW-1:0] reg_len, reg_len_next;
  logic [DPW-1:0] data_pos, data_pos_next;
  logic [DPW-1:0] data_len, data_len_next;

  // Register byte store; read at the running position and at entry zero.
  logic [7:0] reg_store [REG_MAX];

  // Data byte store read port and registered write forward.
  logic          tx_we;
  logic [AW-1:0] tx_waddr;
  logic [AW-1:0] tx_raddr;
  logic [7:0]    tx_rdata;
  logic [7:0]    tx_byte;
  logic          fwd_hit;
  logic [7:0]    fwd_byte;

  logic          reg_we;
  logic          fire;
  out_item_t     res;
  logic [DPW-1:0] data_pos_inc;
  logic [DPW-1:0] dcount_ext;

  // A transfer into the result register happens whenever the input register
  // holds an item and the result register is free or being emptied this cycle.
  assign fire      = iq_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !iq_valid || fire;

  assign data_pos_inc = data_pos + DPW'(1);
  assign dcount_ext   = DPW'(iq.data_count);
  assign tx_waddr     = AW'(iq.load_index);
  assign tx_byte      = fwd_hit ? fwd_byte : tx_rdata;

  // Keep the store reading the byte at the position that holds next cycle.
  assign tx_raddr = fire ? data_pos_next[AW-1:0] : data_pos[AW-1:0];

  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (iq.data_byte),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  // Per-item decision: one pass over the registered item and the state.
  always_comb begin
    res                   = '0;
    phase_next            = phase;
    slave_write_addr_next = slave_write_addr;
    slave_read_addr_next  = slave_read_addr;
    reg_pos_next          = reg_pos;
    reg_len_next          = reg_len;
    data_pos_next         = data_pos;
    data_len_next         = data_len;
    reg_we                = 1'b0;
    tx_we                 = 1'b0;

    unique case (iq.func) inside
      FN_LOAD_REG: begin
        reg_we = fire && (32'(iq.load_index) < REG_MAX);
      end
      FN_LOAD_DATA: begin
        tx_we = fire && (32'(iq.load_index) < TX_DEPTH);
      end
      FN_REQUEST: begin
        if (phase != PH_IDLE) begin
          res.status = 1'b1;
        end else if (iq.kind == KIND_WRITE || iq.kind == KIND_CMD ||
                     iq.kind == KIND_READ) begin
          slave_write_addr_next = iq.write_addr;
          slave_read_addr_next  = iq.read_addr;
          reg_pos_next          = '0;
          reg_len_next          = (32'(iq.reg_count) > REG_MAX) ?
                                  RPW'(REG_MAX) : RPW'(iq.reg_count);
          data_pos_next         = '0;
          res.gen_start         = 1'b1;
          res.ack_enable        = 1'b1;
          case (iq.kind)
            KIND_WRITE: begin
              phase_next    = PH_WRITE;
              data_len_next = (32'(iq.data_count) > TX_DEPTH) ?
                              DPW'(TX_DEPTH) : dcount_ext;
            end
            KIND_CMD: begin
              phase_next    = PH_CMD;
              data_len_next = '0;
            end
            default: begin
              // Read: a count of zero means one byte, cap at the read limit.
              phase_next = PH_TXREG;
              if (dcount_ext == '0) begin
                data_len_next = DPW'(1);
              end else if (32'(iq.data_count) > RX_MAX) begin
                data_len_next = DPW'(RX_MAX);
              end else begin
                data_len_next = dcount_ext;
              end
            end
          endcase
        end
      end
      FN_START_DONE: begin
        if (phase == PH_WRITE || phase == PH_CMD || phase == PH_TXREG) begin
          res.addr_valid = 1'b1;
          res.addr_value = slave_write_addr;
        end else if (phase == PH_RX) begin
          res.addr_valid = 1'b1;
          res.addr_value = slave_read_addr;
          res.addr_read  = 1'b1;
        end
      end
      FN_TX_SEL, FN_BYTE_SENT: begin
        if (phase == PH_CMD && iq.func == FN_TX_SEL) begin
          // Command: first register byte only, then stop.
          if (reg_len != '0) begin
            res.send_valid = 1'b1;
            res.send_value = reg_store[0];
          end
          res.gen_stop = 1'b1;
          phase_next   = PH_IDLE;
        end else if (phase == PH_WRITE || phase == PH_TXREG) begin
          if (reg_pos < reg_len) begin
            res.send_valid = 1'b1;
            res.send_value = reg_store[reg_pos[RW-1:0]];
            reg_pos_next   = reg_pos + RPW'(1);
          end else if (phase == PH_WRITE) begin
            if (data_pos < data_len) begin
              res.send_valid = 1'b1;
              res.send_value = tx_byte;
              data_pos_next  = data_pos_inc;
            end else begin
              res.gen_stop = 1'b1;
              phase_next   = PH_IDLE;
            end
          end else begin
            // Register part of a read done: repeated start.
            res.gen_start = 1'b1;
            phase_next    = PH_RX;
          end
        end
      end
      FN_RX_SEL: begin
      end
      FN_BYTE_RCVD: begin
        if (phase == PH_RX) begin
          res.rx_valid  = 1'b1;
          res.rx_value  = iq.data_byte;
          res.rx_index  = data_pos[7:0];
          if (data_pos_inc >= data_len) begin
            res.gen_stop = 1'b1;
            phase_next   = PH_IDLE;
          end else begin
            res.ack_enable = 1'b1;
          end
          data_pos_next = data_pos_inc;
        end
      end
    endcase
  end

  // Register byte store writes.
  always_ff @(posedge clk) begin
    if (reg_we) begin
      reg_store[RW'(iq.load_index)] <= iq.data_byte;
    end
  end

  // State, input register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid         <= 1'b0;
      rsp.valid        <= 1'b0;
      phase            <= PH_IDLE;
      slave_write_addr <= '0;
      slave_read_addr  <= '0;
      reg_pos          <= '0;
      reg_len          <= '0;
      data_pos         <= '0;
      data_len         <= '0;
      fwd_hit          <= 1'b0;
    end else begin
      // Forward a store write that lands on the address being read.
      fwd_hit <= tx_we && (tx_waddr == tx_raddr);

      if (req.ready) begin
        iq_valid <= req.valid;
      end

      if (fire) begin
        rsp.valid        <= 1'b1;
        phase            <= phase_next;
        slave_write_addr <= slave_write_addr_next;
        slave_read_addr  <= slave_read_addr_next;
        reg_pos          <= reg_pos_next;
        reg_len          <= reg_len_next;
        data_pos         <= data_pos_next;
        data_len         <= data_len_next;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end

    fwd_byte <= iq.data_byte;

    if (req.valid && req.ready) begin
      iq.func       <= func_t'(req.func);
      iq.kind       <= req.kind;
      iq.write_addr <= req.write_addr;
      iq.read_addr  <= req.read_addr;
      iq.reg_count  <= req.reg_count;
      iq.data_count <= req.data_count;
      iq.load_index <= req.load_index;
      iq.data_byte  <= req.data_byte;
    end

    if (fire) begin
      rsp.status     <= res.status;
      rsp.gen_start  <= res.gen_start;
      rsp.addr_valid <= res.addr_valid;
      rsp.addr_value <= res.addr_value;
      rsp.addr_read  <= res.addr_read;
      rsp.send_valid <= res.send_valid;
      rsp.send_value <= res.send_value;
      rsp.gen_stop   <= res.gen_stop;
      rsp.ack_enable <= res.ack_enable;
      rsp.rx_valid   <= res.rx_valid;
      rsp.rx_value   <= res.rx_value;
      rsp.rx_index   <= res.rx_index;
    end
  end

`ifndef NO_ASSERTIONS
  // A request arriving mid-transaction is rejected.
  a_busy_reject: assert property (@(posedge clk) disable iff (rst)
    fire && iq.func == FN_REQUEST && phase != PH_IDLE |=> rsp.valid && rsp.status)
    else $error("busy request not rejected");

  // A stop always ends the transaction.
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.gen_stop |=> phase == PH_IDLE)
    else $error("stop issued without returning to idle");

  // Positions never run past their lengths.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    data_pos <= data_len && reg_pos <= reg_len)
    else $error("position beyond length");

  // At most one of address, byte send and received byte per result.
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> $countones({rsp.addr_valid, rsp.send_valid, rsp.rx_valid}) <= 1)
    else $error("conflicting bus actions in one result");
`endif

endmodule
